/* hw/rtl/smcs_pkg.sv */
// Shared types and constants of the math channel stack.
package smcs_pkg;

   // Number of math channel slots carried through the pipeline.
   localparam int SLOTS = 4;

   // Divider shape: 48 quotient bits, two bits per pipeline stage.
   localparam int DVD_W        = 48;
   localparam int DIV_PER_STG  = 2;
   localparam int DIV_STAGES   = DVD_W / DIV_PER_STG;

   // Control register port.
   localparam int CSR_INDEX_W = 4;
   localparam logic [CSR_INDEX_W-1:0] CSR_SETUP_BASE = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCALE_BASE = 4'd4;
   localparam logic [63:0] SCALE_RESET = 64'h0001_0000_0000_0000;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   typedef struct packed {
      logic [2:0] src_b;
      logic [2:0] src_a;
      logic       invert;
      op_type     op;
      logic       enable;
   } setup_type;

   // Everything that travels down the stack with one sample time.
   typedef struct packed {
      logic signed [31:0]        s0;
      logic signed [31:0]        s1;
      logic [1:0]                rclip;
      logic [SLOTS-1:0][31:0]    mval;
      logic [SLOTS-1:0]          mvalid;
      logic [SLOTS-1:0]          mclip;
   } bundle_type;

endpackage

/* hw/rtl/smcs_req_if.sv */
// Sample input channel of the math channel stack.
interface smcs_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] sample_first;
   logic signed [31:0] sample_second;
   logic [1:0]         real_clip_bits;

   modport source (output valid, sample_first, sample_second, real_clip_bits, input ready);
   modport sink   (input valid, sample_first, sample_second, real_clip_bits, output ready);
endinterface

/* hw/rtl/smcs_rsp_if.sv */
// Result channel of the math channel stack.
interface smcs_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] math_zero;
   logic signed [31:0] math_one;
   logic signed [31:0] math_two;
   logic signed [31:0] math_three;
   logic [3:0]         math_valid_bits;
   logic [3:0]         math_clip_bits;

   modport source (output valid, math_zero, math_one, math_two, math_three,
                   math_valid_bits, math_clip_bits, input ready);
   modport sink   (input valid, math_zero, math_one, math_two, math_three,
                   math_valid_bits, math_clip_bits, output ready);
endinterface

/* hw/rtl/smcs_math_unit.sv */
// One pipelined math channel: source pick, operation, divider, negate and scale.
module smcs_math_unit #(
   parameter int IDX           = 0,
   parameter int REAL_CHANNELS = 2
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  logic                   in_valid,
   input  smcs_pkg::bundle_type   in_bundle,
   input  smcs_pkg::setup_type    setup,
   input  logic [63:0]            scale,
   output logic                   out_valid,
   output smcs_pkg::bundle_type   out_bundle
);

   localparam int DS  = smcs_pkg::DIV_STAGES;
   localparam int LAT = DS + 5;

   typedef struct packed {
      logic               ok;
      logic               clip;
      logic signed [31:0] v;
   } pick_type;

   typedef struct packed {
      smcs_pkg::bundle_type bnd;
      logic                 ok;
      logic                 clip;
      logic signed [31:0]   v0;
      logic signed [31:0]   v1;
   } sel_type;

   typedef struct packed {
      smcs_pkg::bundle_type          bnd;
      logic                          ok;
      logic                          clip;
      logic signed [33:0]            sum;
      logic signed [63:0]            prod;
      logic                          dneg;
      logic                          dzero;
      logic [31:0]                   dvs;
      logic [31:0]                   rem;
      logic [smcs_pkg::DVD_W-1:0]    quo;
   } rec_type;

   typedef struct packed {
      smcs_pkg::bundle_type bnd;
      logic                 ok;
      logic                 clip;
      logic signed [31:0]   r;
   } res_type;

   typedef struct packed {
      smcs_pkg::bundle_type bnd;
      logic                 ok;
      logic                 clip;
      logic signed [63:0]   kp;
   } kmul_type;

   function automatic pick_type pick(input logic [2:0] x, input smcs_pkg::bundle_type b);
      pick_type   p;
      logic [1:0] m;
      p.ok   = 1'b1;
      p.clip = 1'b0;
      p.v    = '0;
      m      = 2'(x - 3'(REAL_CHANNELS));
      if ({1'b0, x} >= 4'(REAL_CHANNELS + IDX)) begin
         p.ok = 1'b0;
      end else if ({1'b0, x} < 4'(REAL_CHANNELS)) begin
         // Real channels past the two inputs read as zero, not clipped.
         if (x < 3'd2) begin
            p.v    = x[0] ? b.s1 : b.s0;
            p.clip = b.rclip[x[0]];
         end
      end else if (!b.mvalid[m]) begin
         p.ok = 1'b0;
      end else begin
         p.v    = b.mval[m];
         p.clip = b.mclip[m];
      end
      return p;
   endfunction

   function automatic rec_type div_step(input rec_type a);
      rec_type     o;
      logic [32:0] t;
      o = a;
      for (int j = 0; j < smcs_pkg::DIV_PER_STG; j++) begin
         t     = {o.rem, o.quo[smcs_pkg::DVD_W-1]};
         o.quo = {o.quo[smcs_pkg::DVD_W-2:0], 1'b0};
         if (t >= {1'b0, o.dvs}) begin
            o.rem    = 32'(t - {1'b0, o.dvs});
            o.quo[0] = 1'b1;
         end else begin
            o.rem = t[31:0];
         end
      end
      return o;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [49:0] r);
      if (r > 50'sd2147483647) begin
         return 32'sh7FFF_FFFF;
      end else if (r < -50'sd2147483648) begin
         return 32'sh8000_0000;
      end
      return 32'(r);
   endfunction

   logic [LAT-1:0] vld_ff;
   sel_type        sel_ff, sel_in;
   rec_type        rec_ff [0:DS];
   rec_type        rec_in;
   res_type        res_ff, res_in;
   kmul_type       kmul_ff, kmul_in;
   smcs_pkg::bundle_type out_ff, out_in;

   // Stage A: pick both sources.
   always_comb begin
      pick_type pa;
      pick_type pb;
      pa = pick(setup.src_a, in_bundle);
      pb = pick(setup.src_b, in_bundle);
      sel_in.bnd  = in_bundle;
      sel_in.ok   = setup.enable & pa.ok & pb.ok;
      sel_in.clip = pa.clip | pb.clip;
      sel_in.v0   = pa.v;
      sel_in.v1   = pb.v;
   end

   // Stage B: add or subtract, full product, divider operands.
   always_comb begin
      logic [31:0] abs_a;
      logic [31:0] abs_b;
      abs_a = sel_ff.v0[31] ? 32'(-sel_ff.v0) : 32'(sel_ff.v0);
      abs_b = sel_ff.v1[31] ? 32'(-sel_ff.v1) : 32'(sel_ff.v1);
      rec_in.bnd  = sel_ff.bnd;
      rec_in.ok   = sel_ff.ok;
      rec_in.clip = sel_ff.clip;
      rec_in.sum  = (setup.op == smcs_pkg::OP_SUB) ? 34'(sel_ff.v0) - 34'(sel_ff.v1)
                                                   : 34'(sel_ff.v0) + 34'(sel_ff.v1);
      rec_in.prod  = 64'(sel_ff.v0) * 64'(sel_ff.v1);
      rec_in.dneg  = sel_ff.v0[31] ^ sel_ff.v1[31];
      rec_in.dzero = (sel_ff.v1 == 32'sd0);
      rec_in.dvs   = abs_b;
      rec_in.rem   = '0;
      rec_in.quo   = {abs_a, 16'h0000};
   end

   // Stage C: choose the operation result, negate, saturate.
   always_comb begin
      logic signed [49:0] r;
      logic signed [49:0] qs;
      qs = $signed({2'b00, rec_ff[DS].quo});
      case (setup.op)
         smcs_pkg::OP_ADD, smcs_pkg::OP_SUB: r = 50'(rec_ff[DS].sum);
         smcs_pkg::OP_MUL: r = 50'(rec_ff[DS].prod >>> 16);
         default:          r = rec_ff[DS].dzero ? 50'sd0 : (rec_ff[DS].dneg ? -qs : qs);
      endcase
      if (setup.invert) begin
         r = -r;
      end
      res_in.bnd  = rec_ff[DS].bnd;
      res_in.ok   = rec_ff[DS].ok;
      res_in.clip = rec_ff[DS].clip;
      res_in.r    = sat32(r);
   end

   // Stage D: gain product.
   always_comb begin
      logic signed [31:0] k;
      k = $signed(scale[63:32]);
      kmul_in.bnd  = res_ff.bnd;
      kmul_in.ok   = res_ff.ok;
      kmul_in.clip = res_ff.clip;
      kmul_in.kp   = 64'(k) * 64'(res_ff.r);
   end

   // Stage E: offset, saturate, publish into the bundle.
   always_comb begin
      logic signed [31:0] b;
      logic signed [49:0] t;
      b = $signed(scale[31:0]);
      t = 50'(kmul_ff.kp >>> 16) + 50'(b);
      out_in             = kmul_ff.bnd;
      out_in.mval[IDX]   = kmul_ff.ok ? sat32(t) : 32'h0;
      out_in.mvalid[IDX] = kmul_ff.ok;
      out_in.mclip[IDX]  = kmul_ff.ok & kmul_ff.clip;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[LAT-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sel_ff    <= sel_in;
         rec_ff[0] <= rec_in;
         for (int k = 0; k < DS; k++) begin
            rec_ff[k+1] <= div_step(rec_ff[k]);
         end
         res_ff  <= res_in;
         kmul_ff <= kmul_in;
         out_ff  <= out_in;
      end
   end

   assign out_valid  = vld_ff[LAT-1];
   assign out_bundle = out_ff;

endmodule

/* hw/rtl/scope_math_channel_stack.sv */
// Top level of the math channel stack: control registers and the channel chain.
//
//   channel   dir   payload                                         handshake
//   req_ch    in    sample_first, sample_second, real_clip_bits     valid / ready
//   rsp_ch    out   math_zero..math_three, valid and clip bits      valid / ready
//   csr_*     in    csr_index, csr_wdata                            csr_we, no wait
//
// One sample time enters per clock while the pipeline advances. Each math
// channel is a 29-stage pipeline (source pick, operation, 24 divider stages at
// two quotient bits each, negate/saturate, gain multiply, offset). Synchronous
// reset empties the pipeline and restores every setup to zero and every scale
// to gain one, offset zero. When a result waits on rsp_ch the whole pipeline
// holds and req_ch.ready drops.
module scope_math_channel_stack #(
   parameter int REAL_CHANNELS = 2,
   parameter int MATH_CHANNELS = 4
) (
   input  logic                               clock,
   input  logic                               reset,
   smcs_req_if.sink                           req_ch,
   smcs_rsp_if.source                         rsp_ch,
   input  logic                               csr_we,
   input  logic [smcs_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [63:0]                        csr_wdata
);

   smcs_pkg::setup_type  setup_ff [MATH_CHANNELS];
   logic [63:0]          scale_ff [MATH_CHANNELS];

   smcs_pkg::bundle_type chain_b [0:MATH_CHANNELS];
   logic                 chain_v [0:MATH_CHANNELS];
   logic                 adv;

   // The pipeline advances unless a finished result is waiting.
   assign adv          = !rsp_ch.valid || rsp_ch.ready;
   assign req_ch.ready = adv;

   // Control registers: setup words take the low ten bits of the write data.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < MATH_CHANNELS; j++) begin
            setup_ff[j] <= '0;
            scale_ff[j] <= smcs_pkg::SCALE_RESET;
         end
      end else if (csr_we) begin
         for (int j = 0; j < MATH_CHANNELS; j++) begin
            if (csr_index == smcs_pkg::CSR_SETUP_BASE + smcs_pkg::CSR_INDEX_W'(j)) begin
               setup_ff[j] <= smcs_pkg::setup_type'(csr_wdata[9:0]);
            end
            if (csr_index == smcs_pkg::CSR_SCALE_BASE + smcs_pkg::CSR_INDEX_W'(j)) begin
               scale_ff[j] <= csr_wdata;
            end
         end
      end
   end

   // The bundle that enters the first channel: real samples, no math results yet.
   always_comb begin
      chain_b[0]        = '0;
      chain_b[0].s0     = req_ch.sample_first;
      chain_b[0].s1     = req_ch.sample_second;
      chain_b[0].rclip  = req_ch.real_clip_bits;
   end
   assign chain_v[0] = req_ch.valid;

   // Each channel reads what the earlier ones left in the bundle.
   for (genvar i = 0; i < MATH_CHANNELS; i++) begin : g_chan
      smcs_math_unit #(
         .IDX           (i),
         .REAL_CHANNELS (REAL_CHANNELS)
      ) u_unit (
         .clock      (clock),
         .reset      (reset),
         .adv        (adv),
         .in_valid   (chain_v[i]),
         .in_bundle  (chain_b[i]),
         .setup      (setup_ff[i]),
         .scale      (scale_ff[i]),
         .out_valid  (chain_v[i+1]),
         .out_bundle (chain_b[i+1])
      );
   end

   assign rsp_ch.valid           = chain_v[MATH_CHANNELS];
   assign rsp_ch.math_zero       = $signed(chain_b[MATH_CHANNELS].mval[0]);
   assign rsp_ch.math_one        = $signed(chain_b[MATH_CHANNELS].mval[1]);
   assign rsp_ch.math_two        = $signed(chain_b[MATH_CHANNELS].mval[2]);
   assign rsp_ch.math_three      = $signed(chain_b[MATH_CHANNELS].mval[3]);
   assign rsp_ch.math_valid_bits = chain_b[MATH_CHANNELS].mvalid;
   assign rsp_ch.math_clip_bits  = chain_b[MATH_CHANNELS].mclip;

   // A clip flag is only ever reported on a valid channel.
   a_clip_needs_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> ((rsp_ch.math_clip_bits & ~rsp_ch.math_valid_bits) == 4'h0))
      else $error("clip bit set on an invalid math channel");

   // An invalid first channel shows a zero value.
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.math_valid_bits[0]) |-> (rsp_ch.math_zero == 32'sd0))
      else $error("invalid math channel carries a nonzero value");

   // Slots past the configured channel count never turn valid.
   a_unused_slots: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> ((rsp_ch.math_valid_bits >> MATH_CHANNELS) == 4'h0))
      else $error("unused math slot reported valid");

endmodule

/* verif/tb_scope_math_channel_stack.sv */
// Self-checking testbench for the scope math channel stack.
`timescale 1ns / 100ps

module tb_scope_math_channel_stack;

   localparam int  CYCLE_LIMIT = 400000;
   localparam int  DRAIN_CYCLES = 150;   // a little over 29 * 4 pipeline stages
   localparam longint Q_MAX = 64'sd2147483647;
   localparam longint Q_MIN = -64'sd2147483648;

   // One sample time as the sender sees it.
   typedef struct packed {
      logic signed [31:0] first;
      logic signed [31:0] second;
      logic [1:0]         clip;
   } sample_type;

   // Expected contents of one result transfer.
   typedef struct packed {
      logic [3:0][31:0] value;
      logic [3:0]       valid_bits;
      logic [3:0]       clip_bits;
   } stack_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [smcs_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [63:0] csr_wdata;

   smcs_req_if req_ch ();
   smcs_rsp_if rsp_ch ();

   scope_math_channel_stack dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch.sink),
      .rsp_ch    (rsp_ch.source),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Shadow copies of the control registers, kept in step with every write.
   smcs_pkg::setup_type setup_shadow [4];
   logic [63:0]         scale_shadow [4];

   sample_type   pending_samples[$];
   stack_type    expected_stacks[$];
   int           mismatch_count;
   int           cycle_count;
   bit           no_idle;       // when set, neither side inserts gaps or stalls
   int           send_gap;
   int           recv_stall;

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   function automatic longint clamp_q(longint v);
      if (v > Q_MAX) return Q_MAX;
      if (v < Q_MIN) return Q_MIN;
      return v;
   endfunction

   // Evaluates all four math channels in order for one sample time, reading
   // earlier channel results out of the stack as it is being filled.
   function automatic stack_type compute_stack(sample_type smp);
      stack_type           r;
      smcs_pkg::setup_type su;
      longint     opnd [2];
      bit         clp [2];
      bit         ok;
      longint     acc;
      longint     gain;
      longint     offs;
      int         src;
      r = '0;
      for (int i = 0; i < 4; i++) begin
         su = setup_shadow[i];
         if (!su.enable) continue;
         ok = 1'b1;
         for (int s = 0; s < 2; s++) begin
            src = (s == 0) ? int'(su.src_a) : int'(su.src_b);
            opnd[s] = 0;
            clp[s] = 1'b0;
            if (src >= 2 + i) begin
               // A source must come strictly before the channel itself.
               ok = 1'b0;
            end else if (src < 2) begin
               opnd[s] = (src == 0) ? longint'(smp.first) : longint'(smp.second);
               clp[s] = smp.clip[src];
            end else if (!r.valid_bits[src-2]) begin
               ok = 1'b0;
            end else begin
               opnd[s] = longint'(signed'(r.value[src-2]));
               clp[s] = r.clip_bits[src-2];
            end
         end
         if (!ok) continue;
         case (su.op)
            smcs_pkg::OP_ADD: acc = opnd[0] + opnd[1];
            smcs_pkg::OP_SUB: acc = opnd[0] - opnd[1];
            smcs_pkg::OP_MUL: acc = (opnd[0] * opnd[1]) >>> 16;
            default: begin
               // Division by zero is defined to give zero.
               acc = (opnd[1] == 0) ? 0 : (opnd[0] * 65536) / opnd[1];
            end
         endcase
         if (su.invert) acc = -acc;
         acc = clamp_q(acc);
         gain = longint'(signed'(scale_shadow[i][63:32]));
         offs = longint'(signed'(scale_shadow[i][31:0]));
         acc = clamp_q(((gain * acc) >>> 16) + offs);
         r.value[i] = acc[31:0];
         r.valid_bits[i] = 1'b1;
         r.clip_bits[i] = clp[0] | clp[1];
      end
      return r;
   endfunction

   // Sender: holds each sample until it transfers, then waits a random gap.
   always @(posedge clock) begin
      sample_type nxt;
      if (reset) begin
         req_ch.valid <= 1'b0;
         send_gap <= 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            expected_stacks.push_back(compute_stack({req_ch.sample_first,
               req_ch.sample_second, req_ch.real_clip_bits}));
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_ch.valid <= 1'b0;
            end else if (pending_samples.size() != 0) begin
               nxt = pending_samples.pop_front();
               req_ch.valid <= 1'b1;
               req_ch.sample_first <= nxt.first;
               req_ch.sample_second <= nxt.second;
               req_ch.real_clip_bits <= nxt.clip;
               send_gap <= no_idle ? 0 : $urandom_range(0, 12);
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: checks every result transfer and stalls at random between them.
   always @(posedge clock) begin
      stack_type want;
      stack_type got;
      int        stall_next;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         recv_stall <= 0;
      end else begin
         stall_next = recv_stall;
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.value[0] = rsp_ch.math_zero;
            got.value[1] = rsp_ch.math_one;
            got.value[2] = rsp_ch.math_two;
            got.value[3] = rsp_ch.math_three;
            got.valid_bits = rsp_ch.math_valid_bits;
            got.clip_bits = rsp_ch.math_clip_bits;
            if (expected_stacks.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("Unexpected result transfer: %h", got);
            end else begin
               want = expected_stacks.pop_front();
               if (got !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     for (int i = 0; i < 4; i++)
                        if (got.value[i] !== want.value[i])
                           $display("math %0d: expected %h, got %h", i,
                                    want.value[i], got.value[i]);
                     if (got.valid_bits !== want.valid_bits)
                        $display("valid bits: expected %b, got %b",
                                 want.valid_bits, got.valid_bits);
                     if (got.clip_bits !== want.clip_bits)
                        $display("clip bits: expected %b, got %b",
                                 want.clip_bits, got.clip_bits);
                  end
               end
            end
            stall_next = no_idle ? 0 : $urandom_range(0, 12);
         end
         if (stall_next > 0) begin
            recv_stall <= stall_next - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            recv_stall <= 0;
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic write_reg(logic [smcs_pkg::CSR_INDEX_W-1:0] idx, logic [63:0] data);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      if (idx < smcs_pkg::CSR_SCALE_BASE)
         setup_shadow[idx[1:0]] = data[9:0];
      else
         scale_shadow[2'(idx - smcs_pkg::CSR_SCALE_BASE)] = data;
   endtask

   // Writes all eight registers back to back, then releases the write enable.
   task automatic load_setup(smcs_pkg::setup_type su [4], logic [63:0] sc [4]);
      for (int i = 0; i < 4; i++)
         write_reg(smcs_pkg::CSR_SETUP_BASE + smcs_pkg::CSR_INDEX_W'(i), 64'(su[i]));
      for (int i = 0; i < 4; i++)
         write_reg(smcs_pkg::CSR_SCALE_BASE + smcs_pkg::CSR_INDEX_W'(i), sc[i]);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Returns once every queued sample has transferred and every result is back.
   task automatic wait_drained();
      while (pending_samples.size() != 0 || req_ch.valid || expected_stacks.size() != 0)
         @(posedge clock);
   endtask

   task automatic queue_sample(logic [31:0] a, logic [31:0] b, logic [1:0] c);
      pending_samples.push_back({a, b, c});
   endtask

   function automatic logic [31:0] pick_sample();
      case ($urandom_range(0, 4))
         0: return $urandom();
         1: return 32'($urandom_range(0, 1 << 21)) - 32'(1 << 20);
         2: return 32'($urandom_range(0, 1 << 17)) - 32'(1 << 16);
         3: return '0;
         default: begin
            case ($urandom_range(0, 3))
               0: return 32'h7FFF_FFFF;
               1: return 32'h8000_0000;
               2: return 32'hFFFF_FFFF;
               default: return 32'h0001_0000;
            endcase
         end
      endcase
   endfunction

   function automatic logic [63:0] pick_scale();
      logic [31:0] k;
      logic [31:0] b;
      case ($urandom_range(0, 5))
         0: return smcs_pkg::SCALE_RESET;
         1: return {$urandom(), $urandom()};
         2: return {32'h7FFF_FFFF, 32'h8000_0000};
         default: begin
            k = 32'($urandom_range(0, 1 << 19)) - 32'(1 << 18);
            b = 32'($urandom_range(0, 1 << 21)) - 32'(1 << 20);
            return {k, b};
         end
      endcase
   endfunction

   initial begin
      smcs_pkg::setup_type su [4];
      logic [63:0]         sc [4];
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.sample_first = '0;
      req_ch.sample_second = '0;
      req_ch.real_clip_bits = '0;
      rsp_ch.ready = 1'b0;
      mismatch_count = 0;
      cycle_count = 0;
      no_idle = 1'b0;
      for (int i = 0; i < 4; i++) begin
         setup_shadow[i] = '0;
         scale_shadow[i] = smcs_pkg::SCALE_RESET;
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // After reset every channel is disabled, so results must be all zero.
      queue_sample(32'h1234_5678, 32'h8000_0000, 2'b11);
      queue_sample(32'h7FFF_FFFF, 32'h0000_0000, 2'b00);
      wait_drained();

      // Directed: one channel per operation, with a chained, inverted source.
      su[0] = '{src_b: 3'd1, src_a: 3'd0, invert: 1'b0, op: smcs_pkg::OP_ADD,
                enable: 1'b1};
      su[1] = '{src_b: 3'd0, src_a: 3'd2, invert: 1'b1, op: smcs_pkg::OP_SUB,
                enable: 1'b1};
      su[2] = '{src_b: 3'd1, src_a: 3'd0, invert: 1'b0, op: smcs_pkg::OP_MUL,
                enable: 1'b1};
      su[3] = '{src_b: 3'd1, src_a: 3'd0, invert: 1'b0, op: smcs_pkg::OP_DIV,
                enable: 1'b1};
      for (int i = 0; i < 4; i++) sc[i] = smcs_pkg::SCALE_RESET;
      load_setup(su, sc);
      queue_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 2'b00);
      queue_sample(32'h8000_0000, 32'h8000_0000, 2'b01);
      queue_sample(32'h8000_0000, 32'h7FFF_FFFF, 2'b10);
      queue_sample(32'h0001_0000, 32'h0000_0000, 2'b11);   // divide by zero
      queue_sample(32'h8000_0000, 32'hFFFF_FFFF, 2'b00);   // quotient overflows
      queue_sample(32'hFFFF_FFFF, 32'h0000_0003, 2'b01);   // truncates toward zero
      queue_sample(32'h0000_0000, 32'h0000_0000, 2'b00);
      queue_sample(32'hFFFF_0000, 32'h0002_8000, 2'b10);
      wait_drained();

      // Directed: sources not strictly earlier, an invalid chained source,
      // and extreme gain and offset.
      su[0] = '{src_b: 3'd2, src_a: 3'd0, invert: 1'b0, op: smcs_pkg::OP_ADD,
                enable: 1'b1};
      su[1] = '{src_b: 3'd0, src_a: 3'd2, invert: 1'b0, op: smcs_pkg::OP_ADD,
                enable: 1'b1};
      su[2] = '{src_b: 3'd1, src_a: 3'd1, invert: 1'b1, op: smcs_pkg::OP_DIV,
                enable: 1'b1};
      su[3] = '{src_b: 3'd7, src_a: 3'd4, invert: 1'b1, op: smcs_pkg::OP_MUL,
                enable: 1'b1};
      sc[0] = {32'h8000_0000, 32'h7FFF_FFFF};
      sc[1] = {32'hFFFF_FFFF, 32'hFFFF_FFFF};
      sc[2] = {32'h7FFF_FFFF, 32'h8000_0000};
      sc[3] = {32'h8000_0000, 32'h8000_0000};
      load_setup(su, sc);
      queue_sample(32'h0003_0000, 32'hFFFE_0000, 2'b11);
      queue_sample(32'h7FFF_FFFF, 32'h0000_0000, 2'b10);
      queue_sample(32'h8000_0000, 32'h0000_0001, 2'b01);
      wait_drained();

      // The last source of channel three points at channel two, which is valid.
      su[3] = '{src_b: 3'd4, src_a: 3'd4, invert: 1'b0, op: smcs_pkg::OP_MUL,
                enable: 1'b1};
      sc[2] = {32'h8000_0000, 32'h0000_0000};
      load_setup(su, sc);
      queue_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 2'b10);
      queue_sample(32'h0000_8000, 32'hFFFF_8000, 2'b00);
      wait_drained();

      // Random phases: mostly enabled channels with legal sources.
      for (int ph = 0; ph < 10; ph++) begin
         no_idle = (ph % 4 == 3);
         for (int i = 0; i < 4; i++) begin
            su[i] = 10'($urandom());
            su[i].enable = ($urandom_range(0, 9) != 0);
            if ($urandom_range(0, 4) != 0) begin
               su[i].src_a = 3'($urandom_range(0, 1 + i));
               su[i].src_b = 3'($urandom_range(0, 1 + i));
            end
            sc[i] = pick_scale();
         end
         load_setup(su, sc);
         for (int n = 0; n < 40; n++)
            queue_sample(pick_sample(), pick_sample(), 2'($urandom()));
         wait_drained();
      end
      no_idle = 1'b0;

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_stacks.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
